>>> hw/rtl/embedding_context_score_macros.svh
// ----------------------------------------------------------------------------
// embedding_context_score_macros.svh
// Assertion macros shared by the checker of the context score block.
// ----------------------------------------------------------------------------
`ifndef EMBEDDING_CONTEXT_SCORE_MACROS_SVH
`define EMBEDDING_CONTEXT_SCORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ECS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg
// Types, sizes and codes shared by the context score block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecs_pkg;

    // Table sizes.
    localparam int VOCAB_SIZE = 4096;
    localparam int VECTOR_DIM = 64;

    // Field widths.
    localparam int FUNC_W    = 2;
    localparam int WORD_W    = 12;
    localparam int ELEM_W    = 6;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 7;
    localparam int SCORE_W   = 48;

    // Derived widths.
    localparam int WORD_AW    = $clog2(VOCAB_SIZE);
    localparam int ELEM_AW    = $clog2(VECTOR_DIM);
    localparam int EMB_AW     = WORD_AW + ELEM_AW;
    localparam int EMB_DEPTH  = VOCAB_SIZE * VECTOR_DIM;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int STEP_W     = PROD_W + ELEM_AW + 1;
    localparam int SUM_W      = SCORE_W + 1;
    localparam int FRAC_SHIFT = 11;

    // Item queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Reset value of the vector length register.
    localparam logic [CFG_W-1:0] VLEN_RESET = CFG_W'(VECTOR_DIM);

    // Saturation limits of the score.
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // Function codes on the input channel.
    localparam logic [FUNC_W-1:0] FUNC_EMB_WR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BIAS_WR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NOISE_WR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCORE    = 2'd3;

    // Decoded command carried through the queue.
    typedef enum logic [1:0] {
        CMD_EMB_WR,
        CMD_BIAS_WR,
        CMD_NOISE_WR,
        CMD_SCORE
    } cmd_t;

    // One queued item.
    typedef struct packed {
        cmd_t                      cmd;
        logic [WORD_W-1:0]         word;
        logic [ELEM_W-1:0]         element;
        logic signed [VALUE_W-1:0] value;
        logic [WORD_W-1:0]         context_word;
        logic                      last;
        logic                      word_ok;
        logic                      ctx_ok;
    } entry_t;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_STEP,
        ST_FINAL
    } state_t;

endpackage

>>> hw/rtl/ecs_front.sv
// ----------------------------------------------------------------------------
// ecs_front
// Accepts input items, decodes the function code, checks index ranges and
// pushes useful items into the queue. Writes out of range are dropped here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecs_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ecs_pkg::FUNC_W-1:0]        s_func,
    input  logic [ecs_pkg::WORD_W-1:0]        s_word,
    input  logic [ecs_pkg::ELEM_W-1:0]        s_element,
    input  logic signed [ecs_pkg::VALUE_W-1:0] s_value,
    input  logic [ecs_pkg::WORD_W-1:0]        s_context_word,
    input  logic                              s_last,
    input  ecs_pkg::queue_status_t            q_status,
    output logic                              q_push,
    output ecs_pkg::entry_t                   q_entry
);

    logic            word_ok;
    logic            ctx_ok;
    logic            elem_ok;
    logic            keep;
    ecs_pkg::cmd_t   cmd;

    // Range checks against the table sizes.
    assign word_ok = (32'(s_word) < ecs_pkg::VOCAB_SIZE);
    assign ctx_ok  = (32'(s_context_word) < ecs_pkg::VOCAB_SIZE);
    assign elem_ok = (32'(s_element) < ecs_pkg::VECTOR_DIM);

    // Decode the function code and decide whether the item does anything.
    always_comb begin
        cmd  = ecs_pkg::CMD_SCORE;
        keep = 1'b1;
        case (s_func)
            ecs_pkg::FUNC_EMB_WR: begin
                cmd  = ecs_pkg::CMD_EMB_WR;
                keep = word_ok && elem_ok;
            end
            ecs_pkg::FUNC_BIAS_WR: begin
                cmd  = ecs_pkg::CMD_BIAS_WR;
                keep = word_ok;
            end
            ecs_pkg::FUNC_NOISE_WR: begin
                cmd  = ecs_pkg::CMD_NOISE_WR;
                keep = word_ok;
            end
            ecs_pkg::FUNC_SCORE: begin
                cmd  = ecs_pkg::CMD_SCORE;
                keep = 1'b1;
            end
            default: begin
                cmd  = ecs_pkg::CMD_SCORE;
                keep = 1'b1;
            end
        endcase
    end

    // An item is taken whenever the queue has room; dropped writes vanish here.
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready && keep;

    always_comb begin
        q_entry.cmd          = cmd;
        q_entry.word         = s_word;
        q_entry.element      = s_element;
        q_entry.value        = s_value;
        q_entry.context_word = s_context_word;
        q_entry.last         = s_last;
        q_entry.word_ok      = word_ok;
        q_entry.ctx_ok       = ctx_ok;
    end

endmodule

>>> hw/rtl/ecs_queue.sv
// ----------------------------------------------------------------------------
// ecs_queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecs_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ecs_pkg::entry_t        push_entry,
    input  logic                   pop,
    output ecs_pkg::entry_t        head,
    output ecs_pkg::queue_status_t status
);

    ecs_pkg::entry_t                 slot_reg [ecs_pkg::QUEUE_DEPTH];
    logic [ecs_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ecs_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ecs_pkg::QUEUE_AW:0]      count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign status.full  = (count_reg == (ecs_pkg::QUEUE_AW+1)'(ecs_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/ecs_back.sv
// ----------------------------------------------------------------------------
// ecs_back
// Holds the tables, performs writes and runs score steps through one
// multiply-accumulate unit, then keeps the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecs_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ecs_pkg::CFG_W-1:0]          cfg_wdata,
    input  ecs_pkg::queue_status_t             q_status,
    input  ecs_pkg::entry_t                    q_head,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ecs_pkg::SCORE_W-1:0] m_score,
    output logic                               m_saturated
);

    // Clamp a sum to the score range; the top bit of the result is the clip flag.
    function automatic logic [ecs_pkg::SCORE_W:0] clamp_score(
        input logic signed [ecs_pkg::SUM_W-1:0] v
    );
        logic ovf;
        ovf = (v[ecs_pkg::SUM_W-1] != v[ecs_pkg::SUM_W-2]);
        if (!ovf) begin
            clamp_score = {1'b0, v[ecs_pkg::SCORE_W-1:0]};
        end else if (v[ecs_pkg::SUM_W-1]) begin
            clamp_score = {1'b1, ecs_pkg::SCORE_MIN};
        end else begin
            clamp_score = {1'b1, ecs_pkg::SCORE_MAX};
        end
    endfunction

    // Tables.
    logic signed [ecs_pkg::VALUE_W-1:0] emb_mem   [ecs_pkg::EMB_DEPTH];
    logic signed [ecs_pkg::VALUE_W-1:0] bias_mem  [ecs_pkg::VOCAB_SIZE];
    logic signed [ecs_pkg::VALUE_W-1:0] noise_mem [ecs_pkg::VOCAB_SIZE];

    ecs_pkg::state_t                    state_reg, state_next;
    logic [ecs_pkg::CFG_W-1:0]          vlen_reg;
    logic [ecs_pkg::CFG_W-1:0]          len_eff;
    logic [ecs_pkg::WORD_AW-1:0]        word_reg;
    logic [ecs_pkg::WORD_AW-1:0]        ctx_reg;
    logic                               last_reg;
    logic                               pair_ok_reg;
    logic                               ctx_ok_reg;
    logic                               word_ok_reg;
    logic [ecs_pkg::ELEM_AW-1:0]        elem_cnt_reg;
    logic                               bias_load_reg;
    logic                               v1_reg;
    logic                               v2_reg;
    logic signed [ecs_pkg::VALUE_W-1:0] emb_a_reg;
    logic signed [ecs_pkg::VALUE_W-1:0] emb_b_reg;
    logic signed [ecs_pkg::VALUE_W-1:0] bias_rd_reg;
    logic signed [ecs_pkg::VALUE_W-1:0] noise_rd_reg;
    logic signed [ecs_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ecs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic signed [ecs_pkg::SCORE_W-1:0] acc_reg;
    logic                               clip_reg;
    logic                               out_valid_reg;
    logic signed [ecs_pkg::SCORE_W-1:0] out_score_reg;
    logic                               out_sat_reg;

    logic                               head_score;
    logic                               score_start;
    logic                               issue;
    logic                               last_issue;
    logic                               pipe_busy;
    logic                               step_commit;
    logic                               final_commit;
    logic                               out_free;
    logic signed [ecs_pkg::STEP_W-1:0]  bias_ext;
    logic signed [ecs_pkg::SUM_W-1:0]   noise_ext;
    logic signed [ecs_pkg::SUM_W-1:0]   acc_sum;
    logic signed [ecs_pkg::SUM_W-1:0]   acc_diff;
    logic [ecs_pkg::SCORE_W:0]          acc_clamped;
    logic [ecs_pkg::SCORE_W:0]          out_clamped;

    // Effective dot-product length, limited to the stored vector size.
    assign len_eff = (vlen_reg > ecs_pkg::CFG_W'(ecs_pkg::VECTOR_DIM)) ?
                     ecs_pkg::CFG_W'(ecs_pkg::VECTOR_DIM) : vlen_reg;

    assign head_score  = (q_head.cmd == ecs_pkg::CMD_SCORE);
    assign last_issue  = ((ecs_pkg::CFG_W'(elem_cnt_reg) + ecs_pkg::CFG_W'(1)) == len_eff);
    assign pipe_busy   = v1_reg || v2_reg || bias_load_reg;
    assign out_free    = !out_valid_reg || m_ready;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ecs_pkg::ST_IDLE: begin
                if (!q_status.empty && head_score) begin
                    state_next = (len_eff == '0) ? ecs_pkg::ST_DRAIN : ecs_pkg::ST_RUN;
                end
            end
            ecs_pkg::ST_RUN: begin
                if (last_issue) begin
                    state_next = ecs_pkg::ST_DRAIN;
                end
            end
            ecs_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = ecs_pkg::ST_STEP;
                end
            end
            ecs_pkg::ST_STEP: begin
                state_next = last_reg ? ecs_pkg::ST_FINAL : ecs_pkg::ST_IDLE;
            end
            ecs_pkg::ST_FINAL: begin
                if (out_free) begin
                    state_next = ecs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ecs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        q_pop        = 1'b0;
        issue        = 1'b0;
        step_commit  = 1'b0;
        final_commit = 1'b0;
        case (state_reg)
            ecs_pkg::ST_IDLE:  q_pop        = !q_status.empty;
            ecs_pkg::ST_RUN:   issue        = 1'b1;
            ecs_pkg::ST_DRAIN: issue        = 1'b0;
            ecs_pkg::ST_STEP:  step_commit  = 1'b1;
            ecs_pkg::ST_FINAL: final_commit = out_free;
            default:           q_pop        = 1'b0;
        endcase
    end

    assign score_start = q_pop && head_score;

    // Sequencer state and configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ecs_pkg::ST_IDLE;
            vlen_reg  <= ecs_pkg::VLEN_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                vlen_reg <= cfg_wdata;
            end
        end
    end

    // Embedding table: one write port, two read ports for target and context.
    always_ff @(posedge aclk) begin
        if (q_pop && (q_head.cmd == ecs_pkg::CMD_EMB_WR)) begin
            emb_mem[{q_head.word[ecs_pkg::WORD_AW-1:0],
                     q_head.element[ecs_pkg::ELEM_AW-1:0]}] <= q_head.value;
        end
        if (issue) begin
            emb_a_reg <= emb_mem[{word_reg, elem_cnt_reg}];
            emb_b_reg <= emb_mem[{ctx_reg, elem_cnt_reg}];
        end
    end

    // Bias and noise tables: written by load items, read once per score step.
    always_ff @(posedge aclk) begin
        if (q_pop && (q_head.cmd == ecs_pkg::CMD_BIAS_WR)) begin
            bias_mem[q_head.word[ecs_pkg::WORD_AW-1:0]] <= q_head.value;
        end
        if (score_start) begin
            bias_rd_reg <= bias_mem[q_head.context_word[ecs_pkg::WORD_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && (q_head.cmd == ecs_pkg::CMD_NOISE_WR)) begin
            noise_mem[q_head.word[ecs_pkg::WORD_AW-1:0]] <= q_head.value;
        end
        if (score_start) begin
            noise_rd_reg <= noise_mem[q_head.word[ecs_pkg::WORD_AW-1:0]];
        end
    end

    // Score step operands, latched when the step leaves the queue.
    always_ff @(posedge aclk) begin
        if (score_start) begin
            word_reg    <= q_head.word[ecs_pkg::WORD_AW-1:0];
            ctx_reg     <= q_head.context_word[ecs_pkg::WORD_AW-1:0];
            last_reg    <= q_head.last;
            pair_ok_reg <= q_head.word_ok && q_head.ctx_ok;
            ctx_ok_reg  <= q_head.ctx_ok;
            word_ok_reg <= q_head.word_ok;
        end
    end

    // Element counter and pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_cnt_reg  <= '0;
            bias_load_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            if (score_start) begin
                elem_cnt_reg <= '0;
            end else if (issue) begin
                elem_cnt_reg <= elem_cnt_reg + 1'b1;
            end
            bias_load_reg <= score_start;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
        end
    end

    // Multiply stage; both operands stay signed so the product is sign-extended.
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            if (pair_ok_reg) begin
                prod_reg <= emb_a_reg * emb_b_reg;
            end else begin
                prod_reg <= '0;
            end
        end
    end

    // Step sum: starts at the context bias in Q.22, then gathers the products.
    assign bias_ext = ctx_ok_reg ?
        $signed({{(ecs_pkg::STEP_W-ecs_pkg::VALUE_W-ecs_pkg::FRAC_SHIFT){bias_rd_reg[ecs_pkg::VALUE_W-1]}},
                 bias_rd_reg, {ecs_pkg::FRAC_SHIFT{1'b0}}}) : '0;

    always_comb begin
        step_next = step_reg;
        if (bias_load_reg) begin
            step_next = bias_ext;
        end else if (v2_reg) begin
            step_next = step_reg + ecs_pkg::STEP_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
    end

    // Accumulator update and final noise subtraction, both saturating.
    assign noise_ext = word_ok_reg ?
        $signed({{(ecs_pkg::SUM_W-ecs_pkg::VALUE_W-ecs_pkg::FRAC_SHIFT){noise_rd_reg[ecs_pkg::VALUE_W-1]}},
                 noise_rd_reg, {ecs_pkg::FRAC_SHIFT{1'b0}}}) : '0;
    assign acc_sum     = ecs_pkg::SUM_W'(acc_reg) + ecs_pkg::SUM_W'(step_reg);
    assign acc_diff    = ecs_pkg::SUM_W'(acc_reg) - noise_ext;
    assign acc_clamped = clamp_score(acc_sum);
    assign out_clamped = clamp_score(acc_diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end else if (step_commit) begin
            acc_reg  <= acc_clamped[ecs_pkg::SCORE_W-1:0];
            clip_reg <= clip_reg || acc_clamped[ecs_pkg::SCORE_W];
        end else if (final_commit) begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end
    end

    // Output register; holds the result item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (final_commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (final_commit) begin
            out_score_reg <= out_clamped[ecs_pkg::SCORE_W-1:0];
            out_sat_reg   <= clip_reg || out_clamped[ecs_pkg::SCORE_W];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_score     = out_score_reg;
    assign m_saturated = out_sat_reg;

endmodule

>>> hw/rtl/embedding_context_score.sv
// ----------------------------------------------------------------------------
// embedding_context_score
// Load items are performed by the back end while it is idle; a score step of
// L = min(vector_length, 64) elements occupies the single multiply-accumulate
// unit, and a step flagged last then also subtracts the noise term of its word.
// Reset clears the queue, accumulator, clip flag and output register and sets
// vector_length to 64; the tables keep their contents and are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module embedding_context_score (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ecs_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ecs_pkg::FUNC_W-1:0]         s_func,
    input  logic [ecs_pkg::WORD_W-1:0]         s_word,
    input  logic [ecs_pkg::ELEM_W-1:0]         s_element,
    input  logic signed [ecs_pkg::VALUE_W-1:0] s_value,
    input  logic [ecs_pkg::WORD_W-1:0]         s_context_word,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ecs_pkg::SCORE_W-1:0] m_score,
    output logic                               m_saturated
);

    ecs_pkg::queue_status_t q_status;
    ecs_pkg::entry_t        q_entry;
    ecs_pkg::entry_t        q_head;
    logic                   q_push;
    logic                   q_pop;

    // Front end: decode and range checks.
    ecs_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_word         (s_word),
        .s_element      (s_element),
        .s_value        (s_value),
        .s_context_word (s_context_word),
        .s_last         (s_last),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    // Item queue between the two halves.
    ecs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    // Back end: tables, multiply-accumulate and result register.
    ecs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_score     (m_score),
        .m_saturated (m_saturated)
    );

endmodule

>>> hw/rtl/ecs_checker.sv
// ----------------------------------------------------------------------------
// ecs_checker
// Port-level checks on the context score block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "embedding_context_score_macros.svh"

module ecs_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [ecs_pkg::SCORE_W-1:0] m_score,
    input logic                               m_saturated
);

    // A stalled result item keeps its value.
    `ECS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_score) && $stable(m_saturated), "result item changed while stalled")

    // A result item leaves only after it was taken.
    `ECS_ASSERT_SAME(a_out_taken, aclk, aresetn, $past(aresetn) && $fell(m_valid), $past(m_ready), "result item dropped without being taken")

    // Leaving reset, no result item is pending.
    `ECS_ASSERT_SAME(a_reset_out, aclk, aresetn, $rose(aresetn), !m_valid, "result item pending after reset")

    // Leaving reset, the empty queue takes input items.
    `ECS_ASSERT_SAME(a_reset_in, aclk, aresetn, $rose(aresetn), s_ready, "input not ready after reset")

endmodule

bind embedding_context_score ecs_checker u_ecs_checker (.*);

>>> bench/tb_embedding_context_score.sv
// ----------------------------------------------------------------------------
// tb_embedding_context_score
// Self-checking bench for the context score block. A scoreboard class keeps
// its own copy of the embedding, bias and noise tables, the accumulator and
// the vector length, and predicts every score. Plain tasks load the tables
// and run directed and random score sequences at several vector lengths,
// including zero and lengths above the vector size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_embedding_context_score;

    // One input item as driven on the s_ channel.
    typedef struct {
        logic [ecs_pkg::FUNC_W-1:0]         func;
        logic [ecs_pkg::WORD_W-1:0]         word;
        logic [ecs_pkg::ELEM_W-1:0]         element;
        logic signed [ecs_pkg::VALUE_W-1:0] value;
        logic [ecs_pkg::WORD_W-1:0]         context_word;
        logic                               last;
    } ecs_item_t;

    // One score as seen on the m_ channel.
    typedef struct {
        logic signed [ecs_pkg::SCORE_W-1:0] score;
        logic                               saturated;
    } score_result_t;

    localparam longint SCORE_HI = ecs_pkg::SCORE_MAX;
    localparam longint SCORE_LO = ecs_pkg::SCORE_MIN;

    // Tracks the table contents and the running context score.
    class context_score_model;
        logic signed [ecs_pkg::VALUE_W-1:0] emb_tab [ecs_pkg::EMB_DEPTH];
        logic signed [ecs_pkg::VALUE_W-1:0] bias_tab [ecs_pkg::VOCAB_SIZE];
        logic signed [ecs_pkg::VALUE_W-1:0] noise_tab [ecs_pkg::VOCAB_SIZE];
        longint                             acc;
        bit                                 clip;
        int unsigned                        vlen;
        score_result_t                      pending_scores[$];
        int                                 errors;

        function new();
            acc = 0;
            clip = 0;
            vlen = ecs_pkg::VECTOR_DIM;
            errors = 0;
        endfunction

        function void set_length(logic [ecs_pkg::CFG_W-1:0] v);
            vlen = 32'(v);
        endfunction

        function longint clamp_score(longint v);
            if (v > SCORE_HI) begin
                clip = 1;
                return SCORE_HI;
            end
            if (v < SCORE_LO) begin
                clip = 1;
                return SCORE_LO;
            end
            return v;
        endfunction

        // Dot product of target and context vectors plus the context bias.
        function longint pair_term(logic [ecs_pkg::WORD_W-1:0] tgt,
                                   logic [ecs_pkg::WORD_W-1:0] ctx);
            int unsigned n;
            longint      s;
            n = (vlen > ecs_pkg::VECTOR_DIM) ? ecs_pkg::VECTOR_DIM : vlen;
            s = 0;
            for (int e = 0; e < n; e++)
                s += longint'(emb_tab[int'(tgt) * ecs_pkg::VECTOR_DIM + e]) *
                     longint'(emb_tab[int'(ctx) * ecs_pkg::VECTOR_DIM + e]);
            s += longint'(bias_tab[ctx]) <<< ecs_pkg::FRAC_SHIFT;
            return s;
        endfunction

        task report(string msg);
            errors++;
            $display("%0t: score mismatch: %s", $time, msg);
        endtask

        // Called for every accepted item.
        task note_item(ecs_item_t it);
            longint        fin;
            score_result_t r;
            case (it.func)
                ecs_pkg::FUNC_EMB_WR:
                    emb_tab[int'(it.word) * ecs_pkg::VECTOR_DIM + int'(it.element)] = it.value;
                ecs_pkg::FUNC_BIAS_WR: bias_tab[it.word] = it.value;
                ecs_pkg::FUNC_NOISE_WR: noise_tab[it.word] = it.value;
                ecs_pkg::FUNC_SCORE: begin
                    acc = clamp_score(acc + pair_term(it.word, it.context_word));
                    if (it.last) begin
                        fin = clamp_score(acc - (longint'(noise_tab[it.word])
                                                 <<< ecs_pkg::FRAC_SHIFT));
                        r.score = fin[ecs_pkg::SCORE_W-1:0];
                        r.saturated = clip;
                        pending_scores.push_back(r);
                        acc = 0;
                        clip = 0;
                    end
                end
                default: begin
                end
            endcase
        endtask

        // Called for every accepted result.
        task check_score(logic signed [ecs_pkg::SCORE_W-1:0] score, logic sat);
            score_result_t want;
            if (pending_scores.size() == 0) begin
                report($sformatf("score %0d arrived with none expected", score));
                return;
            end
            want = pending_scores.pop_front();
            if (score !== want.score)
                report($sformatf("score %0d, expected %0d", score, want.score));
            if (sat !== want.saturated)
                report($sformatf("saturated %b, expected %b", sat, want.saturated));
        endtask
    endclass

    // Words with fixed contents at the extremes of the value range.
    localparam logic [ecs_pkg::WORD_W-1:0] SAT_NEG_WORD = 12'h800;
    localparam logic [ecs_pkg::WORD_W-1:0] SAT_POS_WORD = 12'h7FF;

    localparam logic signed [ecs_pkg::VALUE_W-1:0] VALUE_MIN =
        {1'b1, {(ecs_pkg::VALUE_W-1){1'b0}}};
    localparam logic signed [ecs_pkg::VALUE_W-1:0] VALUE_MAX =
        {1'b0, {(ecs_pkg::VALUE_W-1){1'b1}}};

    localparam int SETTLE_CYCLES   = 400;
    localparam int HOLD_CYCLES     = 500;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PLAIN_COUNT     = 6;

    logic                                aclk;
    logic                                aresetn        = 1'b0;
    logic                                cfg_we         = 1'b0;
    logic [ecs_pkg::CFG_W-1:0]           cfg_wdata      = '0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [ecs_pkg::FUNC_W-1:0]          s_func         = ecs_pkg::FUNC_SCORE;
    logic [ecs_pkg::WORD_W-1:0]          s_word         = '0;
    logic [ecs_pkg::ELEM_W-1:0]          s_element      = '0;
    logic signed [ecs_pkg::VALUE_W-1:0]  s_value        = '0;
    logic [ecs_pkg::WORD_W-1:0]          s_context_word = '0;
    logic                                s_last         = 1'b0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic signed [ecs_pkg::SCORE_W-1:0]  m_score;
    logic                                m_saturated;

    context_score_model          model;
    int                          burst_left = 0;
    logic [ecs_pkg::WORD_W-1:0]  pool_words[$];
    logic [ecs_pkg::WORD_W-1:0]  plain_words[$];
    bit                          word_taken [ecs_pkg::VOCAB_SIZE];
    bit                          fixed_word [ecs_pkg::VOCAB_SIZE];

    embedding_context_score u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_word         (s_word),
        .s_element      (s_element),
        .s_value        (s_value),
        .s_context_word (s_context_word),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_score        (m_score),
        .m_saturated    (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #25_000_000;
        $display("[embedding_context_score] ERROR");
        $finish;
    end

    // Mostly random values, with the extremes and zero mixed in.
    function automatic logic signed [ecs_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            3: return '1;
            default: return ecs_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // Offer one item and wait for it to be taken. Items go out in bursts.
    task automatic send_item(input ecs_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_func         <= it.func;
        s_word         <= it.word;
        s_element      <= it.element;
        s_value        <= it.value;
        s_context_word <= it.context_word;
        s_last         <= it.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model.note_item(it);
        burst_left--;
    endtask

    task automatic load(input logic [ecs_pkg::FUNC_W-1:0] f,
                        input logic [ecs_pkg::WORD_W-1:0] w,
                        input logic [ecs_pkg::ELEM_W-1:0] e,
                        input logic signed [ecs_pkg::VALUE_W-1:0] v);
        ecs_item_t it;
        it.func         = f;
        it.word         = w;
        it.element      = e;
        it.value        = v;
        it.context_word = ecs_pkg::WORD_W'($urandom);
        it.last         = 1'($urandom);
        send_item(it);
    endtask

    task automatic score_step(input logic [ecs_pkg::WORD_W-1:0] tgt,
                              input logic [ecs_pkg::WORD_W-1:0] ctx,
                              input logic last);
        ecs_item_t it;
        it.func         = ecs_pkg::FUNC_SCORE;
        it.word         = tgt;
        it.element      = ecs_pkg::ELEM_W'($urandom);
        it.value        = ecs_pkg::VALUE_W'($urandom);
        it.context_word = ctx;
        it.last         = last;
        send_item(it);
    endtask

    // Write a whole vector, its bias and its noise term.
    task automatic fill_word(input logic [ecs_pkg::WORD_W-1:0] w,
                             input logic signed [ecs_pkg::VALUE_W-1:0] ev,
                             input logic signed [ecs_pkg::VALUE_W-1:0] bv,
                             input logic signed [ecs_pkg::VALUE_W-1:0] nv,
                             input bit scramble);
        for (int e = 0; e < ecs_pkg::VECTOR_DIM; e++)
            load(ecs_pkg::FUNC_EMB_WR, w, ecs_pkg::ELEM_W'(e), scramble ? pick_value() : ev);
        load(ecs_pkg::FUNC_BIAS_WR, w, ecs_pkg::ELEM_W'($urandom), bv);
        load(ecs_pkg::FUNC_NOISE_WR, w, ecs_pkg::ELEM_W'($urandom), nv);
    endtask

    // Stop offering items and let the block drain completely.
    task automatic settle();
        s_valid <= 1'b0;
        while (model.pending_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_length(input logic [ecs_pkg::CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        model.set_length(v);
    endtask

    // Result side: checks every accepted score and stalls in patterns.
    initial begin
        int results_seen;
        int hold_left;
        int seg_left;
        int mode;
        results_seen = 0;
        hold_left = 0;
        seg_left = 0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                model.check_score(m_score, m_saturated);
                results_seen++;
                if (results_seen == 20 || results_seen == 90)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 40);
                    mode = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus.
    initial begin
        logic [ecs_pkg::WORD_W-1:0] w;
        logic [ecs_pkg::CFG_W-1:0]  phase_len[8];
        int                         seq_left;
        int                         pick;
        logic                       last;

        model = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Fixed words first, then words with random contents.
        fill_word(SAT_NEG_WORD, VALUE_MIN, VALUE_MAX, VALUE_MIN, 0);
        fill_word(SAT_POS_WORD, VALUE_MAX, VALUE_MIN, VALUE_MAX, 0);
        pool_words = '{SAT_NEG_WORD, SAT_POS_WORD};
        foreach (pool_words[i]) begin
            word_taken[pool_words[i]] = 1;
            fixed_word[pool_words[i]] = 1;
        end
        plain_words = '{12'h000, 12'hFFF};
        word_taken[12'h000] = 1;
        word_taken[12'hFFF] = 1;
        while (plain_words.size() < PLAIN_COUNT) begin
            w = ecs_pkg::WORD_W'($urandom);
            if (!word_taken[w]) begin
                word_taken[w] = 1;
                plain_words.push_back(w);
            end
        end
        foreach (plain_words[i]) begin
            fill_word(plain_words[i], '0, pick_value(), pick_value(), 1);
            pool_words.push_back(plain_words[i]);
        end

        // Directed: word extremes, full-range values, writes inside a sequence.
        score_step(12'h000, 12'h000, 1);
        score_step(12'hFFF, 12'hFFF, 1);
        score_step(12'h000, 12'hFFF, 0);
        score_step(12'hFFF, 12'h000, 1);
        score_step(SAT_NEG_WORD, SAT_NEG_WORD, 1);
        score_step(SAT_NEG_WORD, SAT_POS_WORD, 1);
        score_step(SAT_POS_WORD, SAT_POS_WORD, 1);
        score_step(12'h000, 12'hFFF, 0);
        load(ecs_pkg::FUNC_BIAS_WR, 12'hFFF, ecs_pkg::ELEM_W'($urandom), VALUE_MIN);
        load(ecs_pkg::FUNC_NOISE_WR, 12'h000, ecs_pkg::ELEM_W'($urandom), VALUE_MAX);
        load(ecs_pkg::FUNC_EMB_WR, 12'h000, 6'h3F, VALUE_MIN);
        score_step(12'h000, 12'hFFF, 1);
        // A zero length leaves only the context bias.
        set_length('0);
        score_step(SAT_NEG_WORD, SAT_NEG_WORD, 1);
        score_step(SAT_POS_WORD, 12'h000, 1);
        set_length(7'd1);
        score_step(SAT_NEG_WORD, SAT_POS_WORD, 1);
        // Lengths above the vector size use the whole vector.
        set_length(7'd127);
        score_step(SAT_NEG_WORD, SAT_NEG_WORD, 1);
        score_step(12'hFFF, 12'h000, 0);
        score_step(12'h000, 12'h000, 1);

        // Random phases, one vector length each.
        phase_len = '{7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(2, 63)),
                      7'($urandom_range(65, 126)), 7'($urandom_range(1, 64)), 7'd64};
        foreach (phase_len[p]) begin
            set_length(phase_len[p]);
            seq_left = 0;
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    // Score sequences of a few steps, now and then cut short or run on.
                    if (seq_left == 0)
                        seq_left = $urandom_range(1, 6);
                    seq_left--;
                    last = (seq_left == 0);
                    if ($urandom_range(0, 19) == 0)
                        last = ~last;
                    score_step(pool_words[$urandom_range(0, pool_words.size() - 1)],
                               pool_words[$urandom_range(0, pool_words.size() - 1)], last);
                end else if (pick < 80) begin
                    load(ecs_pkg::FUNC_EMB_WR, plain_words[$urandom_range(0, PLAIN_COUNT - 1)],
                         ecs_pkg::ELEM_W'($urandom), pick_value());
                end else if (pick < 85) begin
                    load(ecs_pkg::FUNC_BIAS_WR, plain_words[$urandom_range(0, PLAIN_COUNT - 1)],
                         ecs_pkg::ELEM_W'($urandom), pick_value());
                end else if (pick < 90) begin
                    load(ecs_pkg::FUNC_NOISE_WR, plain_words[$urandom_range(0, PLAIN_COUNT - 1)],
                         ecs_pkg::ELEM_W'($urandom), pick_value());
                end else begin
                    // Writes anywhere except the fixed words.
                    do w = ecs_pkg::WORD_W'($urandom); while (fixed_word[w]);
                    case ($urandom_range(0, 2))
                        0: load(ecs_pkg::FUNC_EMB_WR, w, ecs_pkg::ELEM_W'($urandom),
                                ecs_pkg::VALUE_W'($urandom));
                        1: load(ecs_pkg::FUNC_BIAS_WR, w, ecs_pkg::ELEM_W'($urandom),
                                ecs_pkg::VALUE_W'($urandom));
                        default: load(ecs_pkg::FUNC_NOISE_WR, w, ecs_pkg::ELEM_W'($urandom),
                                      ecs_pkg::VALUE_W'($urandom));
                    endcase
                end
            end
        end

        settle();
        if (model.errors == 0)
            $display("[embedding_context_score] OK");
        else
            $display("[embedding_context_score] ERROR");
        $finish;
    end

endmodule
